[design/rc2_cfb1_bit_decrypt_defines.svh]
// assertion macros shared by the checker of the rc2 cfb1 decryptor
// no dependencies
`ifndef RC2_CFB1_BIT_DECRYPT_DEFINES_SVH
`define RC2_CFB1_BIT_DECRYPT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RC2C_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define RC2C_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

[design/rc2c_pkg.sv]
// types, constants and round functions of the rc2 cfb1 decryptor
// no dependencies
package rc2c_pkg;

  localparam int KEY_INDEX_LSB   = 0;
  localparam int KEY_INDEX_W     = 6;
  localparam int KEY_WORD_LSB    = 6;
  localparam int KEY_WORD_W      = 16;
  localparam int CIPHER_BIT_POS  = 22;
  localparam int IN_TDATA_W      = 24;
  localparam int OP_POS          = 0;
  localparam int FRAME_START_POS = 1;
  localparam int IN_TUSER_W      = 2;
  localparam int OUT_TDATA_W     = 8;
  localparam int CHAIN_W         = 64;
  localparam int ROW_W           = 5;
  localparam int ROWS            = 32;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // two key words per step, mashing after rounds 5 and 11
  localparam logic [ROW_W-1:0] MASH_STEP_A = 5'd9;
  localparam logic [ROW_W-1:0] MASH_STEP_B = 5'd21;
  localparam logic [ROW_W-1:0] LAST_STEP   = 5'd31;

  localparam logic [1:0] MASH_X10 = 2'd0;
  localparam logic [1:0] MASH_X32 = 2'd1;
  localparam logic [1:0] MASH_X54 = 2'd2;
  localparam logic [1:0] MASH_X76 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MASH_RD,
    ST_MASH_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             key_wr;
    logic             start;
    logic             mix_en;
    logic             mix_odd;
    logic             mash_rd;
    logic             mash_add;
    logic [1:0]       mash_sel;
    logic [ROW_W-1:0] rd_row;
    logic             finish;
  } dp_cmd_t;

  function automatic logic [15:0] rotl16(input logic [15:0] v, input int s);
    return (v << s) | (v >> (16 - s));
  endfunction

  function automatic logic [15:0] mix_word(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d,
                                           input logic [15:0] k, input int s);
    logic [15:0] t;
    t = a + ((b & ~d) | (c & d)) + k;
    return rotl16(t, s);
  endfunction

endpackage

[design/rc2c_ctrl.sv]
// sequencer of the rc2 cfb1 decryptor: step and mash counters, handshakes
// depends on rc2c_pkg
module rc2c_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_op,
  output logic                out_tvalid,
  input  logic                out_tready,
  output rc2c_pkg::dp_cmd_t   cmd
);

  rc2c_pkg::state_t                state_r, state_nxt;
  logic [rc2c_pkg::ROW_W-1:0]      step_r, step_nxt;
  logic [1:0]                      mash_r, mash_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;
  logic                            in_xfer;

  assign out_free = !out_valid_r || out_tready;
  assign in_xfer  = in_tvalid && (state_r == rc2c_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mash_nxt  = mash_r;
    unique case (state_r)
      rc2c_pkg::ST_IDLE: begin
        if (in_xfer && in_op == rc2c_pkg::OP_DECRYPT) begin
          state_nxt = rc2c_pkg::ST_MIX;
          step_nxt  = '0;
        end
      end
      rc2c_pkg::ST_MIX: begin
        if (step_r == rc2c_pkg::MASH_STEP_A || step_r == rc2c_pkg::MASH_STEP_B) begin
          state_nxt = rc2c_pkg::ST_MASH_RD;
          mash_nxt  = rc2c_pkg::MASH_X10;
        end else if (step_r == rc2c_pkg::LAST_STEP) begin
          state_nxt = rc2c_pkg::ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      rc2c_pkg::ST_MASH_RD: begin
        state_nxt = rc2c_pkg::ST_MASH_ADD;
      end
      rc2c_pkg::ST_MASH_ADD: begin
        if (mash_r == rc2c_pkg::MASH_X76) begin
          state_nxt = rc2c_pkg::ST_MIX;
          step_nxt  = step_r + 1'b1;
        end else begin
          state_nxt = rc2c_pkg::ST_MASH_RD;
          mash_nxt  = mash_r + 1'b1;
        end
      end
      rc2c_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = rc2c_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rc2c_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      rc2c_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.rd_row = '0;
        if (in_xfer) begin
          cmd.key_wr = (in_op == rc2c_pkg::OP_LOAD);
          cmd.start  = (in_op == rc2c_pkg::OP_DECRYPT);
        end
      end
      rc2c_pkg::ST_MIX: begin
        cmd.mix_en  = 1'b1;
        cmd.mix_odd = step_r[0];
        cmd.rd_row  = step_r + 1'b1;
      end
      rc2c_pkg::ST_MASH_RD: begin
        cmd.mash_rd  = 1'b1;
        cmd.mash_sel = mash_r;
      end
      rc2c_pkg::ST_MASH_ADD: begin
        cmd.mash_add = 1'b1;
        cmd.mash_sel = mash_r;
        cmd.rd_row   = step_r + 1'b1;
      end
      rc2c_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc2c_pkg::ST_IDLE;
      step_r      <= '0;
      mash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mash_r      <= mash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[design/rc2c_datapath.sv]
// rc2 datapath: key memory, block words, feedback chain, iv and result bit
// depends on rc2c_pkg
module rc2c_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rc2c_pkg::dp_cmd_t                   cmd,
  input  logic [rc2c_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_frame_start,
  input  logic                                cfg_wr_en,
  input  logic [rc2c_pkg::CHAIN_W-1:0]        cfg_wr_data,
  output logic [rc2c_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // even key words in the low bank, odd ones in the high bank
  logic [15:0] bank_lo [rc2c_pkg::ROWS];
  logic [15:0] bank_hi [rc2c_pkg::ROWS];

  logic [rc2c_pkg::CHAIN_W-1:0]  iv_r, chain_r;
  logic [15:0]                   x10_r, x32_r, x54_r, x76_r;
  logic [15:0]                   key_lo_r, key_hi_r;
  logic                          cbit_r, plain_r;

  logic [rc2c_pkg::KEY_INDEX_W-1:0] key_index;
  logic [15:0]                      key_word;
  logic [rc2c_pkg::CHAIN_W-1:0]     chain_src, enc;
  logic [15:0]                      x10_m, x32_m, x54_m, x76_m;
  logic [15:0]                      mash_src, mash_key;
  logic [rc2c_pkg::ROW_W-1:0]       rd_addr;

  assign key_index = in_tdata[rc2c_pkg::KEY_INDEX_LSB +: rc2c_pkg::KEY_INDEX_W];
  assign key_word  = in_tdata[rc2c_pkg::KEY_WORD_LSB +: rc2c_pkg::KEY_WORD_W];
  assign chain_src = in_frame_start ? iv_r : chain_r;

  assign x10_m = rc2c_pkg::mix_word(x10_r, x32_r, x54_r, x76_r, key_lo_r, 1);
  assign x32_m = rc2c_pkg::mix_word(x32_r, x54_r, x76_r, x10_m, key_hi_r, 2);
  assign x54_m = rc2c_pkg::mix_word(x54_r, x76_r, x10_r, x32_r, key_lo_r, 3);
  assign x76_m = rc2c_pkg::mix_word(x76_r, x10_r, x32_r, x54_m, key_hi_r, 5);

  always_comb begin
    case (cmd.mash_sel)
      rc2c_pkg::MASH_X10: mash_src = x76_r;
      rc2c_pkg::MASH_X32: mash_src = x10_r;
      rc2c_pkg::MASH_X54: mash_src = x32_r;
      default:            mash_src = x54_r;
    endcase
  end

  assign mash_key = mash_src[0] ? key_hi_r : key_lo_r;
  assign rd_addr  = cmd.mash_rd ? mash_src[rc2c_pkg::ROW_W:1] : cmd.rd_row;

  assign enc = {x10_r[7:0], x10_r[15:8], x32_r[7:0], x32_r[15:8],
                x54_r[7:0], x54_r[15:8], x76_r[7:0], x76_r[15:8]};

  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      if (key_index[0]) begin
        bank_hi[key_index[rc2c_pkg::ROW_W:1]] <= key_word;
      end else begin
        bank_lo[key_index[rc2c_pkg::ROW_W:1]] <= key_word;
      end
    end
    key_lo_r <= bank_lo[rd_addr];
    key_hi_r <= bank_hi[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x10_r  <= {chain_src[55:48], chain_src[63:56]};
      x32_r  <= {chain_src[39:32], chain_src[47:40]};
      x54_r  <= {chain_src[23:16], chain_src[31:24]};
      x76_r  <= {chain_src[7:0],   chain_src[15:8]};
      cbit_r <= in_tdata[rc2c_pkg::CIPHER_BIT_POS];
    end else if (cmd.mix_en) begin
      if (cmd.mix_odd) begin
        x54_r <= x54_m;
        x76_r <= x76_m;
      end else begin
        x10_r <= x10_m;
        x32_r <= x32_m;
      end
    end else if (cmd.mash_add) begin
      case (cmd.mash_sel)
        rc2c_pkg::MASH_X10: x10_r <= x10_r + mash_key;
        rc2c_pkg::MASH_X32: x32_r <= x32_r + mash_key;
        rc2c_pkg::MASH_X54: x54_r <= x54_r + mash_key;
        default:            x76_r <= x76_r + mash_key;
      endcase
    end
    if (cmd.finish) begin
      plain_r <= cbit_r ^ x76_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r    <= '0;
      chain_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        iv_r <= cfg_wr_data;
      end
      if (cmd.start) begin
        chain_r <= chain_src;
      end else if (cmd.finish) begin
        chain_r <= {enc[rc2c_pkg::CHAIN_W-2:0], cbit_r};
      end
    end
  end

  assign out_tdata = {{(rc2c_pkg::OUT_TDATA_W-1){1'b0}}, plain_r};

endmodule

[design/rc2_cfb1_bit_decrypt.sv]
// RC2 one-bit cipher feedback decryptor. A load item (in_tuser[0] low) writes one
// expanded 16-bit key word into the 64-word key table and is taken in a single cycle
// with no result. A decrypt item (in_tuser[0] high) optionally reloads the 64-bit
// chain from the iv register (in_tuser[1]), runs the 16 rc2 mixing rounds with the
// two mashing passes on the chain and returns one plain bit in out_tdata[0]. The key
// table is a single read port memory of two words per row: each mixing cycle applies
// two mix steps, each mash word needs a read state and then an add state, so one decrypt
// item occupies the block from its transfer through the start, mix, mash and finish
// steps to its result (the finish waits for a free output register), and in_tready
// stays low meanwhile. A result waiting in the output register does not block the next
// transfer into the block. iv is to be written through cfg_wr_en/cfg_wr_data only while
// the block is idle; the user is bound by this, the block itself does not enforce it. Key
// words that were never loaded read back as unknown values. Depends on rc2c_pkg, rc2c_ctrl and rc2c_datapath
module rc2_cfb1_bit_decrypt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // key_index[5:0], key_word[21:6], cipher_bit[22], zero[23]
  input  logic [rc2c_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op[0], frame_start[1]
  input  logic [rc2c_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // plain_bit[0], zero[7:1]
  output logic [rc2c_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [rc2c_pkg::CHAIN_W-1:0]        cfg_wr_data
);

  rc2c_pkg::dp_cmd_t cmd;

  rc2c_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[rc2c_pkg::OP_POS]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rc2c_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_tdata       (in_tdata),
    .in_frame_start (in_tuser[rc2c_pkg::FRAME_START_POS]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_tdata      (out_tdata)
  );

endmodule

[design/rc2c_checker.sv]
// port-level checks of the rc2 cfb1 decryptor, bound to the top level
// depends on rc2c_pkg and rc2_cfb1_bit_decrypt_defines.svh
`include "rc2_cfb1_bit_decrypt_defines.svh"

module rc2c_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [rc2c_pkg::IN_TUSER_W-1:0]     in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rc2c_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                cfg_wr_en
);

  logic in_xfer;
  logic dec_xfer;
  logic load_xfer;

  assign in_xfer   = in_tvalid && in_tready;
  assign dec_xfer  = in_xfer && (in_tuser[rc2c_pkg::OP_POS] == rc2c_pkg::OP_DECRYPT);
  assign load_xfer = in_xfer && (in_tuser[rc2c_pkg::OP_POS] == rc2c_pkg::OP_LOAD);

  `RC2C_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed while stalled")
  `RC2C_ASSERT_NEXT(a_dec_busy, clk, rst_n, dec_xfer,
    !in_tready, "block ready right after a decrypt transfer")
  `RC2C_ASSERT_NEXT(a_load_ready, clk, rst_n, load_xfer,
    in_tready, "block busy after a key load")
  `RC2C_ASSERT_NOW(a_result_end, clk, rst_n, $rose(out_tvalid) && !cfg_wr_en,
    $rose(in_tready) && out_tdata[rc2c_pkg::OUT_TDATA_W-1:1] == '0,
    "result not at the end of a decrypt")

endmodule

bind rc2_cfb1_bit_decrypt rc2c_checker u_rc2c_checker (.*);

[tb/rc2_cfb1_plain_bit_checker.sv]
`timescale 1ns / 1ps
// plain bit checker for the rc2 cfb1 decryptor: watches the input, output and iv ports,
// keeps its own key table, chain and iv, predicts each plain bit and compares in order
// depends on rc2c_pkg
module rc2_cfb1_plain_bit_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [rc2c_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [rc2c_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [rc2c_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [rc2c_pkg::CHAIN_W-1:0]        cfg_wr_data,
  output int                                  fail_count,
  output int                                  due_count
);

  logic [15:0]                  key_words [64];
  logic [rc2c_pkg::CHAIN_W-1:0] chain_q;
  logic [rc2c_pkg::CHAIN_W-1:0] iv_q;
  logic                         plain_due [$];
  int                           errs;

  function automatic logic [15:0] stir(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c, input logic [15:0] d,
                                       input logic [15:0] k, input int unsigned s);
    logic [15:0] t;
    logic [31:0] twice;
    t = a + (b & ~d) + (c & d) + k;
    twice = {t, t} << s;
    return twice[31:16];
  endfunction

  function automatic logic [63:0] rc2_block_enc(input logic [63:0] blk);
    logic [15:0] w [4];
    logic [15:0] sel;
    int r;
    int j;
    w[0] = {blk[55:48], blk[63:56]};
    w[1] = {blk[39:32], blk[47:40]};
    w[2] = {blk[23:16], blk[31:24]};
    w[3] = {blk[7:0],   blk[15:8]};
    for (r = 0; r < 16; r++) begin
      w[0] = stir(w[0], w[1], w[2], w[3], key_words[4*r],     1);
      w[1] = stir(w[1], w[2], w[3], w[0], key_words[4*r + 1], 2);
      w[2] = stir(w[2], w[3], w[0], w[1], key_words[4*r + 2], 3);
      w[3] = stir(w[3], w[0], w[1], w[2], key_words[4*r + 3], 5);
      // mashing after rounds 5 and 11
      if (r == 4 || r == 10) begin
        for (j = 0; j < 4; j++) begin
          sel = w[(j + 3) % 4];
          w[j] = w[j] + key_words[sel[5:0]];
        end
      end
    end
    return {w[0][7:0], w[0][15:8], w[1][7:0], w[1][15:8],
            w[2][7:0], w[2][15:8], w[3][7:0], w[3][15:8]};
  endfunction

  always @(posedge clk) begin
    logic [63:0] enc;
    logic        cbit;
    logic        want;
    if (!rst_n) begin
      chain_q = '0;
      iv_q = '0;
      plain_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (plain_due.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected plain bit transfer: got %b", out_tdata[0]);
        end else begin
          want = plain_due.pop_front();
          if (out_tdata[0] !== want) begin
            errs++;
            if (errs <= 10)
              $display("plain bit mismatch: expected %b, got %b", want, out_tdata[0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[rc2c_pkg::OP_POS] == rc2c_pkg::OP_LOAD) begin
          key_words[in_tdata[rc2c_pkg::KEY_INDEX_LSB +: rc2c_pkg::KEY_INDEX_W]] =
            in_tdata[rc2c_pkg::KEY_WORD_LSB +: rc2c_pkg::KEY_WORD_W];
        end else begin
          cbit = in_tdata[rc2c_pkg::CIPHER_BIT_POS];
          if (in_tuser[rc2c_pkg::FRAME_START_POS]) chain_q = iv_q;
          enc = rc2_block_enc(chain_q);
          plain_due.push_back(cbit ^ enc[0]);
          chain_q = {enc[62:0], cbit};
        end
      end
      if (cfg_wr_en) iv_q = cfg_wr_data;
    end
    fail_count <= errs;
    due_count <= plain_due.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// top of the rc2 cfb1 decryptor regression: clock, reset, key loads, directed and random
// cipher bits under three idling modes, one long output stall and the verdict
// depends on rc2c_pkg, rc2_cfb1_bit_decrypt and rc2_cfb1_plain_bit_checker
module testbench;

  localparam int ITEMS_PER_PHASE = 458;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 60;

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [rc2c_pkg::IN_TDATA_W-1:0]    in_tdata;
  logic [rc2c_pkg::IN_TUSER_W-1:0]    in_tuser;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [rc2c_pkg::OUT_TDATA_W-1:0]   out_tdata;
  logic                               cfg_wr_en;
  logic [rc2c_pkg::CHAIN_W-1:0]       cfg_wr_data;

  int   fail_count;
  int   due_count;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   phase;
  int   quiet_cycles;
  logic hold_off;

  rc2_cfb1_bit_decrypt i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  rc2_cfb1_plain_bit_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .due_count   (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= !hold_off && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_off = 1'b0;
    wait (phase == 2);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (700) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("rc2_cfb1_bit_decrypt regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic op, input logic [5:0] idx, input logic [15:0] word,
                           input logic cbit, input logic fs);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, cbit, word, idx};
    in_tuser  <= {fs, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_iv(input logic [rc2c_pkg::CHAIN_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] word;
    int          i;
    int          p;
    int          n;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    rst_n        = 1'b0;
    phase        = 0;
    snd_idle_pct = 6;
    rcv_idle_pct = 71;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // whole key table loaded before any decrypt reads it
    for (i = 0; i < 64; i++) begin
      word = (i == 0) ? 16'h0000 : (i == 63) ? 16'hffff : 16'($urandom);
      send_item(rc2c_pkg::OP_LOAD, 6'(i), word, 1'($urandom), 1'($urandom));
    end

    // chain straight from reset, then frame start with the reset iv
    send_item(rc2c_pkg::OP_DECRYPT, 6'h3f, 16'hffff, 1'b0, 1'b0);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h00, 16'h0000, 1'b1, 1'b0);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h15, 16'h5555, 1'b1, 1'b1);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h2a, 16'haaaa, 1'b0, 1'b0);
    settle();
    write_iv('1);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h00, 16'h0000, 1'b0, 1'b1);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h3f, 16'hffff, 1'b1, 1'b0);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h01, 16'h8000, 1'b0, 1'b0);
    send_item(rc2c_pkg::OP_LOAD, 6'h3f, 16'h0000, 1'b1, 1'b1);
    send_item(rc2c_pkg::OP_LOAD, 6'h00, 16'hffff, 1'b0, 1'b0);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h20, 16'h0001, 1'b1, 1'b1);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h1f, 16'h7fff, 1'b0, 1'b0);
    settle();
    write_iv('0);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h00, 16'h0000, 1'b1, 1'b1);
    send_item(rc2c_pkg::OP_DECRYPT, 6'h3f, 16'hffff, 1'b1, 1'b0);

    for (p = 0; p < 3; p++) begin
      settle();
      phase = p;
      snd_idle_pct = (p == 0) ? 6 : (p == 1) ? 71 : 0;
      rcv_idle_pct = (p == 0) ? 71 : (p == 1) ? 6 : 0;
      write_iv((p == 1) ? '1 : {$urandom, $urandom});
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 12)
          send_item(rc2c_pkg::OP_LOAD, 6'($urandom), 16'($urandom), 1'($urandom),
                    1'($urandom));
        else
          send_item(rc2c_pkg::OP_DECRYPT, 6'($urandom), 16'($urandom), 1'($urandom),
                    $urandom_range(0, 15) == 0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("rc2_cfb1_bit_decrypt regression: pass");
    end else begin
      $display("rc2_cfb1_bit_decrypt regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/rc2c_pkg.sv
design/rc2c_ctrl.sv
design/rc2c_datapath.sv
design/rc2_cfb1_bit_decrypt.sv
design/rc2c_checker.sv
tb/rc2_cfb1_plain_bit_checker.sv
tb/testbench.sv
